### hdl/ucl_pkg.sv
// ============================================================================
// ucl_pkg
// Shared types, codes and sizes of the UTF-8 character to clip lookup block.
// ============================================================================
package ucl_pkg;

    localparam int DICT_DEPTH_DEF = 8192;

    localparam int CMD_W     = 2;
    localparam int BYTE_W    = 8;
    localparam int SLOT_W    = 13;
    localparam int KEY_W     = 21;
    localparam int CLIP_W    = 16;
    localparam int STATUS_W  = 2;
    localparam int COUNT_W   = 16;
    localparam int ENTRIES_W = 14;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 16;

    localparam logic [CMD_W-1:0] CMD_TEXT  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_WRITE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_START = 2'd2;

    localparam logic [STATUS_W-1:0] ST_ACCEPT  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOMATCH = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_INVALID = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_DICT_ENTRIES = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CLIP_LIMIT   = 1'd1;

    typedef struct packed {
        logic             start;
        logic [KEY_W-1:0] key;
    } search_req_t;

    typedef struct packed {
        logic              done;
        logic              found;
        logic [CLIP_W-1:0] clip;
    } search_rsp_t;

endpackage

### hdl/ucl_if.sv
// ============================================================================
// ucl_in_if / ucl_out_if
// Valid/ready channels for commands in and lookup results out.
// ============================================================================
interface ucl_in_if
    import ucl_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  cmd;
    logic [BYTE_W-1:0] text_byte;
    logic [SLOT_W-1:0] entry_slot;
    logic [KEY_W-1:0]  entry_key;
    logic [CLIP_W-1:0] entry_clip;

    modport source (output valid, cmd, text_byte, entry_slot, entry_key, entry_clip,
                    input ready);
    modport sink   (input valid, cmd, text_byte, entry_slot, entry_key, entry_clip,
                    output ready);
endinterface

interface ucl_out_if
    import ucl_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [KEY_W-1:0]    code_point;
    logic [CLIP_W-1:0]   clip_id;
    logic [COUNT_W-1:0]  accepted_count;

    modport source (output valid, status, code_point, clip_id, accepted_count,
                    input ready);
    modport sink   (input valid, status, code_point, clip_id, accepted_count,
                    output ready);
endinterface

### hdl/ucl_dict_mem.sv
// ============================================================================
// ucl_dict_mem
// Dictionary storage: key and clip id per slot, one write and one
// registered read port.
// ============================================================================
module ucl_dict_mem
    import ucl_pkg::*;
#(
    parameter int DICT_DEPTH = DICT_DEPTH_DEF,
    parameter int AW         = (DICT_DEPTH > 1) ? $clog2(DICT_DEPTH) : 1
)
(
    input  logic              clk,
    input  logic              we,
    input  logic [AW-1:0]     waddr,
    input  logic [KEY_W-1:0]  wkey,
    input  logic [CLIP_W-1:0] wclip,
    input  logic              re,
    input  logic [AW-1:0]     raddr,
    output logic [KEY_W-1:0]  rkey,
    output logic [CLIP_W-1:0] rclip
);

    logic [KEY_W-1:0]  key_mem  [DICT_DEPTH];
    logic [CLIP_W-1:0] clip_mem [DICT_DEPTH];
    logic [KEY_W-1:0]  rkey_reg;
    logic [CLIP_W-1:0] rclip_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            key_mem[waddr]  <= wkey;
            clip_mem[waddr] <= wclip;
        end
        if (re)
        begin
            rkey_reg  <= key_mem[raddr];
            rclip_reg <= clip_mem[raddr];
        end
    end

    assign rkey  = rkey_reg;
    assign rclip = rclip_reg;

endmodule

### hdl/ucl_search.sv
// ============================================================================
// ucl_search
// Binary search sequencer: one shared compare per probe over the sorted
// dictionary, each probe a registered read (S_PROBE) then a compare (S_CMP).
// ============================================================================
module ucl_search
    import ucl_pkg::*;
#(
    parameter int DICT_DEPTH = DICT_DEPTH_DEF,
    parameter int AW         = (DICT_DEPTH > 1) ? $clog2(DICT_DEPTH) : 1,
    parameter int CW         = $clog2(DICT_DEPTH + 1)
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  search_req_t       req,
    input  logic [CW-1:0]     count,
    output logic              rd_en,
    output logic [AW-1:0]     rd_addr,
    input  logic [KEY_W-1:0]  rd_key,
    input  logic [CLIP_W-1:0] rd_clip,
    output search_rsp_t       rsp
);

    typedef enum logic [1:0] {S_IDLE, S_PROBE, S_CMP} state_t;

    state_t            state_reg, state_next;
    logic [CW-1:0]     lo_reg, lo_next;
    logic [CW-1:0]     hi_reg, hi_next;
    logic [CW-1:0]     mid_reg, mid_next;
    logic [KEY_W-1:0]  key_reg, key_next;
    search_rsp_t       rsp_reg, rsp_next;
    logic [CW:0]       span_sum;
    logic [CW-1:0]     mid_comb;

    // hi_reg holds the upper bound plus one
    assign span_sum = {1'b0, lo_reg} + {1'b0, hi_reg} - {{CW{1'b0}}, 1'b1};
    assign mid_comb = span_sum[CW:1];
    assign rd_en    = (state_reg == S_PROBE) && (lo_reg < hi_reg);
    assign rd_addr  = mid_comb[AW-1:0];

    always_comb
    begin
        state_next = state_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        mid_next   = mid_reg;
        key_next   = key_reg;
        rsp_next   = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (req.start)
                begin
                    lo_next    = '0;
                    hi_next    = count;
                    key_next   = req.key;
                    state_next = S_PROBE;
                end
            end
            S_PROBE:
            begin
                if (lo_reg < hi_reg)
                begin
                    mid_next   = mid_comb;
                    state_next = S_CMP;
                end
                else
                begin
                    rsp_next.done = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            S_CMP:
            begin
                if (rd_key == key_reg)
                begin
                    rsp_next.done  = 1'b1;
                    rsp_next.found = 1'b1;
                    rsp_next.clip  = rd_clip;
                    state_next     = S_IDLE;
                end
                else
                begin
                    if (rd_key < key_reg)
                        lo_next = mid_reg + CW'(1);
                    else
                        hi_next = mid_reg;
                    state_next = S_PROBE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            rsp_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            rsp_reg   <= rsp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg  <= lo_next;
        hi_reg  <= hi_next;
        mid_reg <= mid_next;
        key_reg <= key_next;
    end

    assign rsp = rsp_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_reg.found |-> rsp_reg.done)
        else $error("search reported a match without completion");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CMP) |=> (state_reg == S_PROBE) || rsp_reg.done)
        else $error("compare step neither advanced nor finished");

    assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |-> (mid_comb < count) || (state_reg != S_PROBE))
        else $error("probe address beyond the entry count");

endmodule

### hdl/utf8_char_to_clip_lookup_top.sv
// ============================================================================
// utf8_char_to_clip_lookup_top
// UTF-8 decoder with binary search lookup of clip ids in a loaded dictionary.
// ============================================================================
// Commands arrive one per transfer: text bytes, dictionary writes and text
// starts. Dictionary writes, text starts and bytes that neither complete a
// character nor are an invalid lead are done in the idle state; an invalid
// lead byte also passes through the emit state. A completed character runs a
// binary search through the dictionary memory, each probe a registered read
// and then a compare; the input is not ready while the search runs. Results
// sit in an output register, so the next command is taken while a result
// waits. The dictionary has no reset; search only over slots that were
// written.
module utf8_char_to_clip_lookup_top
    import ucl_pkg::*;
#(
    parameter int DICT_DEPTH = DICT_DEPTH_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata,
    ucl_in_if.sink               in_ch,
    ucl_out_if.source            out_ch
);

    localparam int AW = (DICT_DEPTH > 1) ? $clog2(DICT_DEPTH) : 1;
    localparam int CW = $clog2(DICT_DEPTH + 1);

    typedef enum logic [1:0] {T_IDLE, T_SEARCH, T_EMIT} state_t;

    state_t              state_reg;
    logic [ENTRIES_W-1:0] dict_entries_reg;
    logic [CLIP_W-1:0]   clip_limit_reg;
    logic [KEY_W-1:0]    partial_reg;
    logic [1:0]          pending_reg;
    logic                halted_reg;
    logic [COUNT_W-1:0]  total_reg;
    logic [STATUS_W-1:0] pend_status_reg;
    logic [KEY_W-1:0]    pend_code_reg;
    logic [CLIP_W-1:0]   pend_clip_reg;
    logic                out_valid_reg;
    logic [STATUS_W-1:0] out_status_reg;
    logic [KEY_W-1:0]    out_code_reg;
    logic [CLIP_W-1:0]   out_clip_reg;
    logic [COUNT_W-1:0]  out_count_reg;

    search_req_t         srch_req;
    search_rsp_t         srch_rsp;
    logic [CW-1:0]       count;
    logic                rd_en;
    logic [AW-1:0]       rd_addr;
    logic [KEY_W-1:0]    rd_key;
    logic [CLIP_W-1:0]   rd_clip;
    logic                in_xfer;
    logic                mem_we;
    logic                out_load;
    logic [KEY_W-1:0]    cont_code;
    logic [BYTE_W-1:0]   b;
    logic [COUNT_W-1:0]  total_inc;

    assign in_ch.ready = (state_reg == T_IDLE);
    assign in_xfer     = in_ch.valid && in_ch.ready;
    assign b           = in_ch.text_byte;
    assign cont_code   = {partial_reg[KEY_W-7:0], b[5:0]};
    assign out_load    = (state_reg == T_EMIT) && (!out_valid_reg || out_ch.ready);
    assign total_inc   = (total_reg == '1) ? total_reg : total_reg + COUNT_W'(1);

    assign count = ({18'd0, dict_entries_reg} > 32'(DICT_DEPTH)) ? CW'(DICT_DEPTH)
                                                              : CW'(dict_entries_reg);

    assign mem_we = in_xfer && (in_ch.cmd == CMD_WRITE)
                    && ({19'd0, in_ch.entry_slot} < 32'(DICT_DEPTH));

    // Start a search when a text byte completes a character
    always_comb
    begin
        srch_req = '0;
        if (in_xfer && (in_ch.cmd == CMD_TEXT) && !halted_reg)
        begin
            if (pending_reg != 2'd0)
            begin
                srch_req.start = (pending_reg == 2'd1);
                srch_req.key   = cont_code;
            end
            else if ((b != 8'h00) && (b < 8'h80))
            begin
                srch_req.start = 1'b1;
                srch_req.key   = {13'd0, b};
            end
        end
    end

    ucl_dict_mem #(.DICT_DEPTH(DICT_DEPTH), .AW(AW)) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (AW'(in_ch.entry_slot)),
        .wkey  (in_ch.entry_key),
        .wclip (in_ch.entry_clip),
        .re    (rd_en),
        .raddr (rd_addr),
        .rkey  (rd_key),
        .rclip (rd_clip)
    );

    ucl_search #(.DICT_DEPTH(DICT_DEPTH), .AW(AW), .CW(CW)) u_search (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (srch_req),
        .count   (count),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_key  (rd_key),
        .rd_clip (rd_clip),
        .rsp     (srch_rsp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= T_IDLE;
            dict_entries_reg <= '0;
            clip_limit_reg   <= '0;
            partial_reg      <= '0;
            pending_reg      <= '0;
            halted_reg       <= 1'b0;
            total_reg        <= '0;
            pend_status_reg  <= ST_ACCEPT;
            pend_code_reg    <= '0;
            pend_clip_reg    <= '0;
            out_valid_reg    <= 1'b0;
            out_status_reg   <= ST_ACCEPT;
            out_code_reg     <= '0;
            out_clip_reg     <= '0;
            out_count_reg    <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_DICT_ENTRIES: dict_entries_reg <= cfg_wdata[ENTRIES_W-1:0];
                    REG_CLIP_LIMIT:   clip_limit_reg   <= cfg_wdata;
                    default:          ;
                endcase
            end

            if (out_valid_reg && out_ch.ready && !out_load)
                out_valid_reg <= 1'b0;

            case (state_reg)
                T_IDLE:
                begin
                    if (in_xfer)
                    begin
                        case (in_ch.cmd)
                            CMD_START:
                            begin
                                partial_reg <= '0;
                                pending_reg <= '0;
                                halted_reg  <= 1'b0;
                                total_reg   <= '0;
                            end
                            CMD_TEXT:
                            begin
                                if (!halted_reg)
                                begin
                                    if (pending_reg != 2'd0)
                                    begin
                                        partial_reg   <= cont_code;
                                        pending_reg   <= pending_reg - 2'd1;
                                        pend_code_reg <= cont_code;
                                        if (pending_reg == 2'd1)
                                            state_reg <= T_SEARCH;
                                    end
                                    else if (b == 8'h00)
                                        halted_reg <= 1'b1;
                                    else if (b < 8'h80)
                                    begin
                                        pend_code_reg <= {13'd0, b};
                                        state_reg     <= T_SEARCH;
                                    end
                                    else if ((b & 8'he0) == 8'hc0)
                                    begin
                                        partial_reg <= {16'd0, b[4:0]};
                                        pending_reg <= 2'd1;
                                    end
                                    else if ((b & 8'hf0) == 8'he0)
                                    begin
                                        partial_reg <= {17'd0, b[3:0]};
                                        pending_reg <= 2'd2;
                                    end
                                    else if ((b & 8'hf8) == 8'hf0)
                                    begin
                                        partial_reg <= {18'd0, b[2:0]};
                                        pending_reg <= 2'd3;
                                    end
                                    else
                                    begin
                                        halted_reg      <= 1'b1;
                                        pend_status_reg <= ST_INVALID;
                                        pend_code_reg   <= '0;
                                        pend_clip_reg   <= '0;
                                        state_reg       <= T_EMIT;
                                    end
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                T_SEARCH:
                begin
                    if (srch_rsp.done)
                    begin
                        if (!srch_rsp.found)
                        begin
                            pend_status_reg <= ST_NOMATCH;
                            pend_clip_reg   <= '0;
                        end
                        else
                        begin
                            pend_clip_reg <= srch_rsp.clip;
                            if (({1'b0, srch_rsp.clip} + 17'd1) < {1'b0, clip_limit_reg})
                                pend_status_reg <= ST_ACCEPT;
                            else
                                pend_status_reg <= ST_RANGE;
                        end
                        state_reg <= T_EMIT;
                    end
                end
                T_EMIT:
                begin
                    if (out_load)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_status_reg <= pend_status_reg;
                        out_code_reg   <= pend_code_reg;
                        out_clip_reg   <= pend_clip_reg;
                        if (pend_status_reg == ST_ACCEPT)
                        begin
                            total_reg     <= total_inc;
                            out_count_reg <= total_inc;
                        end
                        else
                            out_count_reg <= total_reg;
                        state_reg <= T_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= T_IDLE;
                end
            endcase
        end
    end

    assign out_ch.valid          = out_valid_reg;
    assign out_ch.status         = out_status_reg;
    assign out_ch.code_point     = out_code_reg;
    assign out_ch.clip_id        = out_clip_reg;
    assign out_ch.accepted_count = out_count_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        srch_rsp.done |-> (state_reg == T_SEARCH))
        else $error("search finished outside a lookup");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> out_valid_reg)
        else $error("result load lost");

    assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && (in_ch.cmd != CMD_TEXT)) |=> (state_reg == T_IDLE))
        else $error("non-text command started a lookup");

    assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && (in_ch.cmd == CMD_TEXT) && halted_reg) |=> (state_reg == T_IDLE))
        else $error("halted text produced work");

endmodule
